[design/frustum_box_visibility_test_assert.svh]
// Assertion macros for the checker file of the frustum box visibility test
`ifndef FRUSTUM_BOX_VISIBILITY_TEST_ASSERT_SVH
`define FRUSTUM_BOX_VISIBILITY_TEST_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define FBV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define FBV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/fbv_pkg.sv]
// Package: constants and control types of the frustum box visibility test
`timescale 1ns / 1ps

package fbv_pkg;

   localparam int PLANE_COUNT   = 6;
   localparam int PLANE_IDX_W   = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int PLANE_INDEX_W = 3;
   localparam int NORMAL_W      = 16;
   localparam int COORD_W       = 32;
   localparam int PROD_W        = NORMAL_W + COORD_W;
   localparam int DIST_W        = PROD_W + 2;
   localparam int Q_SHIFT       = 14;

   localparam logic signed [COORD_W-1:0] THRESHOLD_RESET = -32'sd1274;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   typedef struct packed {
      logic                   load;
      logic                   capture;
      logic                   issue;
      logic [PLANE_IDX_W-1:0] plane;
      logic                   emit;
   } fbv_cmd_type;

   typedef struct packed {
      logic pipe_empty;
   } fbv_status_type;

endpackage

[design/fbv_ctrl.sv]
// Controller: sequences plane issue, pipeline drain and result handoff
`timescale 1ns / 1ps

module fbv_ctrl
   import fbv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_op,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output fbv_cmd_type    cmd,
   input  fbv_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type              state_ff,     state_in;
   logic [PLANE_IDX_W-1:0] plane_cnt_ff, plane_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   last_plane;
   logic                   slot_free;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign accept     = req_valid && req_ready;
   assign last_plane = (plane_cnt_ff == PLANE_IDX_W'(PLANE_COUNT - 1));
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      plane_cnt_in = plane_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.plane    = plane_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_TEST) begin
                  cmd.capture  = 1'b1;
                  plane_cnt_in = '0;
                  state_in     = ST_RUN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (last_plane) begin
               state_in = ST_DRAIN;
            end else begin
               plane_cnt_in = plane_cnt_ff + PLANE_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // hand off once the last distance is folded in and the output word is free
            if (status.pipe_empty && slot_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         plane_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         plane_cnt_ff <= plane_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[design/fbv_datapath.sv]
// Datapath: plane store, threshold register, distance pipeline and result register
`timescale 1ns / 1ps

module fbv_datapath
   import fbv_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  fbv_cmd_type                     cmd,
   output fbv_status_type                  status,
   input  logic                            csr_wr_en,
   input  logic signed [COORD_W-1:0]       csr_wr_data,
   input  logic        [PLANE_INDEX_W-1:0] req_plane_index,
   input  logic signed [NORMAL_W-1:0]      req_normal_x,
   input  logic signed [NORMAL_W-1:0]      req_normal_y,
   input  logic signed [NORMAL_W-1:0]      req_normal_z,
   input  logic signed [COORD_W-1:0]       req_plane_offset,
   input  logic signed [COORD_W-1:0]       req_min_x,
   input  logic signed [COORD_W-1:0]       req_min_y,
   input  logic signed [COORD_W-1:0]       req_min_z,
   input  logic signed [COORD_W-1:0]       req_max_x,
   input  logic signed [COORD_W-1:0]       req_max_y,
   input  logic signed [COORD_W-1:0]       req_max_z,
   output logic                            rsp_visible
);

   // plane store
   logic signed [NORMAL_W-1:0] nx_ff  [PLANE_COUNT];
   logic signed [NORMAL_W-1:0] ny_ff  [PLANE_COUNT];
   logic signed [NORMAL_W-1:0] nz_ff  [PLANE_COUNT];
   logic signed [COORD_W-1:0]  off_ff [PLANE_COUNT];
   logic                       wr_hit;
   logic [PLANE_IDX_W-1:0]     wr_idx;

   logic signed [COORD_W-1:0] thr_ff;

   // captured box
   logic signed [COORD_W-1:0] min_x_ff, min_y_ff, min_z_ff;
   logic signed [COORD_W-1:0] max_x_ff, max_y_ff, max_z_ff;

   // stage 1: products
   logic signed [NORMAL_W-1:0] nx_sel, ny_sel, nz_sel;
   logic signed [COORD_W-1:0]  off_sel;
   logic signed [COORD_W-1:0]  cx, cy, cz;
   logic signed [PROD_W-1:0]   prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0]   prod_y_ff, prod_y_in;
   logic signed [PROD_W-1:0]   prod_z_ff, prod_z_in;
   logic signed [DIST_W-1:0]   off_s1_ff, off_s1_in;
   logic                       s1_valid_ff;

   // stage 2: partial sums
   logic signed [DIST_W-1:0] sum_a_ff, sum_a_in;
   logic signed [DIST_W-1:0] sum_b_ff, sum_b_in;
   logic                     s2_valid_ff;

   // stage 3: distance, compare, cull flag
   logic signed [DIST_W-1:0] dist_sum;
   logic signed [DIST_W-1:0] thr_scaled;
   logic                     cull_ff;
   logic                     rsp_visible_ff;

   assign wr_hit = cmd.load && (32'(req_plane_index) < 32'(PLANE_COUNT));
   assign wr_idx = req_plane_index[PLANE_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PLANE_COUNT; i++) begin
            nx_ff[i]  <= '0;
            ny_ff[i]  <= '0;
            nz_ff[i]  <= '0;
            off_ff[i] <= '0;
         end
      end else if (wr_hit) begin
         nx_ff[wr_idx]  <= req_normal_x;
         ny_ff[wr_idx]  <= req_normal_y;
         nz_ff[wr_idx]  <= req_normal_z;
         off_ff[wr_idx] <= req_plane_offset;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         min_x_ff <= req_min_x;
         min_y_ff <= req_min_y;
         min_z_ff <= req_min_z;
         max_x_ff <= req_max_x;
         max_y_ff <= req_max_y;
         max_z_ff <= req_max_z;
      end
   end

   // p-vertex: minimum where the normal component is negative, else maximum
   assign nx_sel  = nx_ff[cmd.plane];
   assign ny_sel  = ny_ff[cmd.plane];
   assign nz_sel  = nz_ff[cmd.plane];
   assign off_sel = off_ff[cmd.plane];
   assign cx      = nx_sel[NORMAL_W-1] ? min_x_ff : max_x_ff;
   assign cy      = ny_sel[NORMAL_W-1] ? min_y_ff : max_y_ff;
   assign cz      = nz_sel[NORMAL_W-1] ? min_z_ff : max_z_ff;

   assign prod_x_in = PROD_W'(nx_sel) * PROD_W'(cx);
   assign prod_y_in = PROD_W'(ny_sel) * PROD_W'(cy);
   assign prod_z_in = PROD_W'(nz_sel) * PROD_W'(cz);
   assign off_s1_in = DIST_W'(off_sel) <<< Q_SHIFT;

   assign sum_a_in = DIST_W'(prod_x_ff) + DIST_W'(prod_y_ff);
   assign sum_b_in = DIST_W'(prod_z_ff) + off_s1_ff;

   assign dist_sum   = sum_a_ff + sum_b_ff;
   assign thr_scaled = DIST_W'(thr_ff) <<< Q_SHIFT;

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      prod_z_ff <= prod_z_in;
      off_s1_ff <= off_s1_in;
      sum_a_ff  <= sum_a_in;
      sum_b_ff  <= sum_b_in;
      if (cmd.emit) begin
         rsp_visible_ff <= !cull_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         cull_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         // clear on a new box, set once any plane falls strictly below the threshold
         if (cmd.capture) begin
            cull_ff <= 1'b0;
         end else if (s2_valid_ff && (dist_sum < thr_scaled)) begin
            cull_ff <= 1'b1;
         end
      end
   end

   assign status.pipe_empty = !s1_valid_ff && !s2_valid_ff;
   assign rsp_visible       = rsp_visible_ff;

endmodule

[design/frustum_box_visibility_test.sv]
// Top level: frustum box visibility test, controller plus datapath
//
// Input channel (req_*): valid/ready. req_op selects the word kind. A load word
// writes normal and offset into plane slot req_plane_index (slots beyond the
// plane count are ignored) and returns nothing. A test word carries a box
// (min and max corners) and returns one rsp_visible word: 0 when some plane's
// distance to the box's p-vertex is strictly below csr_wr_data's threshold.
// The distance unit handles one plane per cycle over a three-stage pipeline
// (products, partial sums, distance and compare); a box runs over every stored
// plane plus pipeline drain, one box at a time. A load word leaves the block
// ready for the next word.
// The result sits in an output register, so a finished word may wait for
// rsp_ready; while it waits the block still accepts load words, and a following
// box runs and holds its own result until the register frees up.
// csr_wr_en writes the cull threshold; the user must do so only while idle, as the block does not enforce it.
// Reset (synchronous): all planes cleared to zero, threshold set to -1274
// (Q16.16), no result pending.
`timescale 1ns / 1ps

module frustum_box_visibility_test
   import fbv_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic signed [COORD_W-1:0]       csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_op,
   input  logic        [PLANE_INDEX_W-1:0] req_plane_index,
   input  logic signed [NORMAL_W-1:0]      req_normal_x,
   input  logic signed [NORMAL_W-1:0]      req_normal_y,
   input  logic signed [NORMAL_W-1:0]      req_normal_z,
   input  logic signed [COORD_W-1:0]       req_plane_offset,
   input  logic signed [COORD_W-1:0]       req_min_x,
   input  logic signed [COORD_W-1:0]       req_min_y,
   input  logic signed [COORD_W-1:0]       req_min_z,
   input  logic signed [COORD_W-1:0]       req_max_x,
   input  logic signed [COORD_W-1:0]       req_max_y,
   input  logic signed [COORD_W-1:0]       req_max_z,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_visible
);

   fbv_cmd_type    cmd;
   fbv_status_type status;

   fbv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   fbv_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_plane_index  (req_plane_index),
      .req_normal_x     (req_normal_x),
      .req_normal_y     (req_normal_y),
      .req_normal_z     (req_normal_z),
      .req_plane_offset (req_plane_offset),
      .req_min_x        (req_min_x),
      .req_min_y        (req_min_y),
      .req_min_z        (req_min_z),
      .req_max_x        (req_max_x),
      .req_max_y        (req_max_y),
      .req_max_z        (req_max_z),
      .rsp_visible      (rsp_visible)
   );

endmodule

[design/fbv_checker.sv]
// Port-level checker for the frustum box visibility test, bound to the top level
`timescale 1ns / 1ps
`include "frustum_box_visibility_test_assert.svh"

module fbv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_op,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_visible
);

   // a stalled result word holds
`FBV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp_valid dropped while stalled")
`FBV_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_visible), "rsp_visible changed while stalled")
   // a test word occupies the block, so no word follows in the next cycle
`FBV_ASSERT_NEXT(a_test_busy, clock, reset, req_valid && req_ready && req_op, !req_ready, "input ready right after a test word")
   // a load word never produces a result
`FBV_ASSERT_NEXT(a_load_silent, clock, reset, req_valid && req_ready && !req_op && !rsp_valid, !rsp_valid, "result appeared after a load word")

endmodule

bind frustum_box_visibility_test fbv_checker u_fbv_checker (.*);

[tb/tb_frustum_box_visibility_test.sv]
// Testbench for the frustum box visibility test: random and directed words, self-checking
`timescale 1ns / 1ps

module tb_frustum_box_visibility_test;
   import fbv_pkg::*;

   typedef logic signed [COORD_W-1:0]  coord_type;
   typedef logic signed [NORMAL_W-1:0] normal_type;

   typedef struct {
      logic                     op;
      logic [PLANE_INDEX_W-1:0] plane_index;
      normal_type               normal_x;
      normal_type               normal_y;
      normal_type               normal_z;
      coord_type                plane_offset;
      coord_type                min_x;
      coord_type                min_y;
      coord_type                min_z;
      coord_type                max_x;
      coord_type                max_y;
      coord_type                max_z;
   } box_word_type;

   localparam longint Q30_SCALE = longint'(1) << Q_SHIFT;
   localparam int     CHUNK_WORDS = 165;
   localparam int     SETTLE_CYCLES = 12;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   coord_type  csr_wr_data = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_op = OP_LOAD;
   logic [PLANE_INDEX_W-1:0] req_plane_index = '0;
   normal_type req_normal_x = '0;
   normal_type req_normal_y = '0;
   normal_type req_normal_z = '0;
   coord_type  req_plane_offset = '0;
   coord_type  req_min_x = '0;
   coord_type  req_min_y = '0;
   coord_type  req_min_z = '0;
   coord_type  req_max_x = '0;
   coord_type  req_max_y = '0;
   coord_type  req_max_z = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_visible;

   // plane store and threshold as the block should hold them
   normal_type   stored_normal [PLANE_COUNT][3];
   coord_type    stored_offset [PLANE_COUNT];
   coord_type    cull_limit = THRESHOLD_RESET;

   box_word_type pending_words[$];
   bit           visible_due[$];
   box_word_type issued_word;
   box_word_type next_word;
   bit           due_visible;
   int           mismatch_count = 0;
   int           tx_idle_pct = 0;
   int           rx_idle_pct = 0;
   int           chunk;
   coord_type    chunk_limit [6];

   frustum_box_visibility_test DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_plane_index  (req_plane_index),
      .req_normal_x     (req_normal_x),
      .req_normal_y     (req_normal_y),
      .req_normal_z     (req_normal_z),
      .req_plane_offset (req_plane_offset),
      .req_min_x        (req_min_x),
      .req_min_y        (req_min_y),
      .req_min_z        (req_min_z),
      .req_max_x        (req_max_x),
      .req_max_y        (req_max_y),
      .req_max_z        (req_max_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_visible      (rsp_visible)
   );

   always #5 clock = ~clock;

   // p-vertex term: minimum coordinate for a negative normal, else maximum
   function automatic longint axis_term(input normal_type n, input coord_type lo,
                                        input coord_type hi);
      return (n < 0) ? longint'(n) * longint'(lo) : longint'(n) * longint'(hi);
   endfunction

   function automatic bit box_survives(input box_word_type w);
      longint plane_dist;
      longint limit;
      limit = longint'(cull_limit) * Q30_SCALE;
      for (int p = 0; p < PLANE_COUNT; p++) begin
         plane_dist = axis_term(stored_normal[p][0], w.min_x, w.max_x)
                    + axis_term(stored_normal[p][1], w.min_y, w.max_y)
                    + axis_term(stored_normal[p][2], w.min_z, w.max_z)
                    + longint'(stored_offset[p]) * Q30_SCALE;
         if (plane_dist < limit) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic record_word(input box_word_type w);
      if (w.op == OP_LOAD) begin
         if (w.plane_index < PLANE_COUNT) begin
            stored_normal[w.plane_index][0] = w.normal_x;
            stored_normal[w.plane_index][1] = w.normal_y;
            stored_normal[w.plane_index][2] = w.normal_z;
            stored_offset[w.plane_index]    = w.plane_offset;
         end
      end else begin
         visible_due.push_back(box_survives(w));
      end
   endtask

   // every field random, so ignored fields toggle too
   function automatic box_word_type noise_word();
      box_word_type w;
      w.op           = 1'($urandom);
      w.plane_index  = PLANE_INDEX_W'($urandom);
      w.normal_x     = normal_type'($urandom);
      w.normal_y     = normal_type'($urandom);
      w.normal_z     = normal_type'($urandom);
      w.plane_offset = coord_type'($urandom);
      w.min_x        = coord_type'($urandom);
      w.min_y        = coord_type'($urandom);
      w.min_z        = coord_type'($urandom);
      w.max_x        = coord_type'($urandom);
      w.max_y        = coord_type'($urandom);
      w.max_z        = coord_type'($urandom);
      return w;
   endfunction

   function automatic box_word_type load_word(input int idx, input normal_type nx,
                                              input normal_type ny, input normal_type nz,
                                              input coord_type off);
      box_word_type w;
      w = noise_word();
      w.op           = OP_LOAD;
      w.plane_index  = PLANE_INDEX_W'(idx);
      w.normal_x     = nx;
      w.normal_y     = ny;
      w.normal_z     = nz;
      w.plane_offset = off;
      return w;
   endfunction

   function automatic box_word_type test_word(input coord_type lx, input coord_type ly,
                                              input coord_type lz, input coord_type hx,
                                              input coord_type hy, input coord_type hz);
      box_word_type w;
      w = noise_word();
      w.op    = OP_TEST;
      w.min_x = lx;
      w.min_y = ly;
      w.min_z = lz;
      w.max_x = hx;
      w.max_y = hy;
      w.max_z = hz;
      return w;
   endfunction

   function automatic normal_type rand_normal();
      case ($urandom_range(7))
         0:       return normal_type'(16'sh8000);
         1:       return normal_type'(16'sh7FFF);
         2:       return '0;
         default: return normal_type'($urandom);
      endcase
   endfunction

   // mostly boxes within +-16 units, sometimes anywhere
   function automatic coord_type rand_coord();
      if ($urandom_range(3) == 0) return coord_type'($urandom);
      return coord_type'(int'($urandom_range(2097152)) - 1048576);
   endfunction

   function automatic box_word_type random_word();
      box_word_type w;
      w = noise_word();
      if ($urandom_range(99) < 25) begin
         w.op = OP_LOAD;
         if ($urandom_range(9) != 0) w.plane_index = PLANE_INDEX_W'($urandom_range(PLANE_COUNT - 1));
         case ($urandom_range(7))
            0: begin
               // neutral plane: zero normal and a random non-negative offset
               w.normal_x = '0;
               w.normal_y = '0;
               w.normal_z = '0;
               w.plane_offset = coord_type'($urandom_range(32'h7FFFFFFF));
            end
            1: begin
               w.normal_x = '0;
               w.normal_y = '0;
               w.normal_z = '0;
               w.plane_offset = '0;
            end
            default: begin
               w.normal_x = rand_normal();
               w.normal_y = rand_normal();
               w.normal_z = rand_normal();
               if ($urandom_range(3) != 0)
                  w.plane_offset = coord_type'(int'($urandom_range(16777216)) - 1048576);
            end
         endcase
      end else begin
         w.op    = OP_TEST;
         w.min_x = rand_coord();
         w.min_y = rand_coord();
         w.min_z = rand_coord();
         w.max_x = rand_coord();
         w.max_y = rand_coord();
         w.max_z = rand_coord();
      end
      return w;
   endfunction

   // sample on the falling edge so all edge updates have settled
   task automatic wait_for_drain();
      @(negedge clock);
      while (pending_words.size() != 0 || req_valid || visible_due.size() != 0)
         @(negedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int p = 0; p < PLANE_COUNT; p++) begin
            stored_normal[p][0] = '0;
            stored_normal[p][1] = '0;
            stored_normal[p][2] = '0;
            stored_offset[p]    = '0;
         end
      end else begin
         if (req_valid && req_ready) record_word(issued_word);
         // hold the word until accepted
         if (!req_valid || req_ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
               next_word = pending_words.pop_front();
               issued_word      <= next_word;
               req_op           <= next_word.op;
               req_plane_index  <= next_word.plane_index;
               req_normal_x     <= next_word.normal_x;
               req_normal_y     <= next_word.normal_y;
               req_normal_z     <= next_word.normal_z;
               req_plane_offset <= next_word.plane_offset;
               req_min_x        <= next_word.min_x;
               req_min_y        <= next_word.min_y;
               req_min_z        <= next_word.min_z;
               req_max_x        <= next_word.max_x;
               req_max_y        <= next_word.max_y;
               req_max_z        <= next_word.max_z;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (visible_due.size() == 0) begin
               $error("result word with none expected: visible=%0b", rsp_visible);
               mismatch_count++;
            end else begin
               due_visible = visible_due.pop_front();
               if (rsp_visible !== due_visible) begin
                  $error("visible mismatch: expected %0b, actual %0b", due_visible, rsp_visible);
                  mismatch_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   initial begin
      chunk_limit[0] = THRESHOLD_RESET;
      chunk_limit[1] = coord_type'(32'h7FFFFFFF);
      chunk_limit[2] = coord_type'(32'h80000000);
      chunk_limit[3] = '0;
      chunk_limit[4] = coord_type'($urandom);
      chunk_limit[5] = coord_type'(int'($urandom_range(2097152)) - 1048576);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (chunk = 0; chunk < 6; chunk++) begin
         if (chunk > 0) begin
            // let trailing words and their results finish before touching the threshold
            wait_for_drain();
            repeat (SETTLE_CYCLES) @(posedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= chunk_limit[chunk];
            cull_limit  = chunk_limit[chunk];
            @(posedge clock);
            csr_wr_en   <= 1'b0;
            @(negedge clock);
         end
         tx_idle_pct = (chunk < 2) ? 31 : (chunk < 4) ? 46 : 0;
         rx_idle_pct = (chunk < 2) ? 46 : (chunk < 4) ? 31 : 0;

         if (chunk == 0) begin
            // cleared planes: distance zero stays visible
            pending_words.push_back(test_word(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
            // distance equal to the threshold does not cull, one below does
            pending_words.push_back(load_word(0, '0, '0, '0, THRESHOLD_RESET));
            pending_words.push_back(test_word(0, 0, 0, 0, 0, 0));
            pending_words.push_back(load_word(0, '0, '0, '0, THRESHOLD_RESET - 1));
            pending_words.push_back(test_word(0, 0, 0, 0, 0, 0));
            pending_words.push_back(load_word(0, 16'sh8000, 16'sh7FFF, '0, 32'sh7FFFFFFF));
            // slots past the plane count are dropped
            pending_words.push_back(load_word(6, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'sh80000000));
            pending_words.push_back(load_word(7, 16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000));
            pending_words.push_back(test_word(0, 0, 0, 0, 0, 0));
            pending_words.push_back(load_word(1, 16'sh7FFF, 16'sh8000, 16'sh8000, 32'sh80000000));
            pending_words.push_back(load_word(2, '0, '0, -16'sd1, 32'sh7FFFFFFF));
            pending_words.push_back(load_word(3, '0, '0, '0, 32'sh7FFFFFFF));
            pending_words.push_back(load_word(4, '0, '0, '0, 32'sh7FFFFFFF));
            pending_words.push_back(load_word(5, '0, '0, '0, 32'sh7FFFFFFF));
            pending_words.push_back(test_word(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
            // inverted box
            pending_words.push_back(test_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                              32'sh80000000, 32'sh80000000, 32'sh80000000));
            pending_words.push_back(test_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                                              32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
            pending_words.push_back(test_word(32'sh80000000, 32'sh80000000, 32'sh80000000,
                                              32'sh80000000, 32'sh80000000, 32'sh80000000));
            pending_words.push_back(load_word(1, '0, '0, '0, '0));
            pending_words.push_back(test_word(-32'sd65536, 32'sd65536, 0, 32'sd65536, 0, -32'sd1));
            pending_words.push_back(load_word(2, '0, '0, '0, '0));
            pending_words.push_back(test_word(0, 0, 0, 0, 0, 0));
         end

         for (int i = 0; i < CHUNK_WORDS; i++) pending_words.push_back(random_word());
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+design
design/fbv_pkg.sv
design/fbv_ctrl.sv
design/fbv_datapath.sv
design/frustum_box_visibility_test.sv
design/fbv_checker.sv
tb/tb_frustum_box_visibility_test.sv
